>>> src/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under reset
`define IBIT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ibit assertion failed");

// next-cycle implication under reset
`define IBIT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ibit assertion failed");

`endif

>>> src/ibit_pkg.sv
package ibit_pkg;

    localparam int POS_W  = 10;
    localparam int ITEM_W = 12;
    localparam int PTR_W  = 13;
    localparam int FIELD_W = 32;
    localparam int CFG_W  = 13;
    localparam int NPOS_W = 11;
    localparam int NCON_W = 13;

    localparam logic [2:0] MODE_LOAD_CONS  = 3'd0;
    localparam logic [2:0] MODE_LOAD_START = 3'd1;
    localparam logic [2:0] MODE_PREPARE    = 3'd2;
    localparam logic [2:0] MODE_QUERY      = 3'd3;
    localparam logic [2:0] MODE_RESTORE    = 3'd4;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD_INDEX  = 2'd1;
    localparam logic [1:0] ST_INFEASIBLE = 2'd2;

    localparam logic CFG_NUM_POSITIONS   = 1'b0;
    localparam logic CFG_NUM_CONSTRAINTS = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_WR_LOAD,
        S_Q_RD,
        S_Q_LOAD,
        S_Q_MERGE,
        S_P_RD,
        S_P_INIT,
        S_P_LAT,
        S_W_RD,
        S_W_CHK,
        S_WB,
        S_R_RD,
        S_R_WR,
        S_FINISH
    } ibit_state_t;

    typedef struct packed {
        logic capture;
        logic wr_load;
        logic load_self;
        logic rd_next;
        logic rd_start1;
        logic merge_next;
        logic latch_start1;
        logic init_prep;
        logic walk_step;
        logic write_back;
        logic copy_snap;
        logic clr_cnt;
        logic finish;
    } ibit_cmd_t;

    typedef struct packed {
        logic [2:0] mode;
        logic       mode_ok;
        logic       reached_eq;
        logic       walk_go;
        logic       walk_block;
        logic       cnt_last;
        logic       np_zero;
        logic       out_busy;
    } ibit_sts_t;

endpackage

>>> src/ibit_ram.sv
module ibit_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> src/ibit_ctrl.sv
module ibit_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  ibit_pkg::ibit_sts_t sts,
    output ibit_pkg::ibit_cmd_t cmd
);
    import ibit_pkg::*;

    ibit_state_t state_reg;
    ibit_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (sts.mode) inside
                    MODE_LOAD_CONS, MODE_LOAD_START:
                        state_next = sts.mode_ok ? S_WR_LOAD : S_FINISH;
                    MODE_PREPARE:
                        state_next = sts.mode_ok ? S_P_RD : S_FINISH;
                    MODE_QUERY:
                        state_next = sts.mode_ok ? S_Q_RD : S_FINISH;
                    MODE_RESTORE:
                        state_next = sts.np_zero ? S_FINISH : S_R_RD;
                    default:
                        state_next = S_FINISH;
                endcase
            end
            S_WR_LOAD: state_next = S_FINISH;
            S_Q_RD:    state_next = S_Q_LOAD;
            S_Q_LOAD:  state_next = S_Q_MERGE;
            S_Q_MERGE: state_next = sts.reached_eq ? S_FINISH : S_W_RD;
            S_P_RD:    state_next = S_P_INIT;
            S_P_INIT:  state_next = S_P_LAT;
            S_P_LAT:   state_next = S_W_RD;
            S_W_RD:    state_next = S_W_CHK;
            S_W_CHK:   state_next = (sts.walk_go && !sts.walk_block) ? S_W_RD : S_WB;
            S_WB:      state_next = S_FINISH;
            S_R_RD:    state_next = S_R_WR;
            S_R_WR:    state_next = sts.cnt_last ? S_FINISH : S_R_RD;
            S_FINISH:
            begin
                if (!sts.out_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
            end
            S_DISPATCH: cmd.clr_cnt = 1'b1;
            S_WR_LOAD:  cmd.wr_load = 1'b1;
            S_Q_LOAD:
            begin
                cmd.load_self = 1'b1;
                cmd.rd_next   = 1'b1;
                cmd.rd_start1 = 1'b1;
            end
            S_Q_MERGE:
            begin
                cmd.merge_next   = !sts.reached_eq;
                cmd.latch_start1 = 1'b1;
            end
            S_P_INIT:
            begin
                cmd.init_prep = 1'b1;
                cmd.rd_start1 = 1'b1;
            end
            S_P_LAT:    cmd.latch_start1 = 1'b1;
            S_W_CHK:    cmd.walk_step = 1'b1;
            S_WB:       cmd.write_back = 1'b1;
            S_R_WR:     cmd.copy_snap = 1'b1;
            S_FINISH:   cmd.finish = !sts.out_busy;
            default:    cmd = '0;
        endcase
    end

endmodule

>>> src/ibit_dp.sv
module ibit_dp #(
    parameter int MAX_POSITIONS   = 1024,
    parameter int MAX_CONSTRAINTS = 4096,
    parameter int BOUND_WIDTH     = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [ibit_pkg::CFG_W-1:0]        cfg_data,
    input  logic [2:0]                        mode,
    input  logic [ibit_pkg::ITEM_W-1:0]       item_index,
    input  logic [ibit_pkg::POS_W-1:0]        position,
    input  logic [ibit_pkg::POS_W-1:0]        right_position,
    input  logic                              start_present,
    input  logic [ibit_pkg::POS_W-1:0]        constraint_right,
    input  logic signed [ibit_pkg::FIELD_W-1:0] lower_in,
    input  logic signed [ibit_pkg::FIELD_W-1:0] upper_in,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [ibit_pkg::FIELD_W-1:0] lower_out,
    output logic signed [ibit_pkg::FIELD_W-1:0] upper_out,
    output logic                              feasible,
    output logic [1:0]                        status,
    input  ibit_pkg::ibit_cmd_t               cmd,
    output ibit_pkg::ibit_sts_t               sts
);
    import ibit_pkg::*;

    localparam int BW  = BOUND_WIDTH;
    localparam int PW  = $clog2(MAX_POSITIONS);
    localparam int CW  = (MAX_CONSTRAINTS > 1) ? $clog2(MAX_CONSTRAINTS) : 1;
    localparam int NPW = ($clog2(MAX_POSITIONS + 1) > NPOS_W) ?
                         $clog2(MAX_POSITIONS + 1) : NPOS_W;
    localparam int NCW = ($clog2(MAX_CONSTRAINTS + 1) > NCON_W) ?
                         $clog2(MAX_CONSTRAINTS + 1) : NCON_W;
    localparam int CONS_DW  = POS_W + 2 * BW;
    localparam int START_DW = 1 + ITEM_W;
    localparam int STATE_DW = 1 + PTR_W + POS_W + 2 * BW;
    localparam logic [63:0] BMAX_U = (64'd1 << (BW - 1)) - 64'd1;
    localparam logic signed [BW-1:0] BMAX = BW'(BMAX_U);
    localparam logic signed [BW-1:0] BMIN = ~BMAX;

    function automatic logic signed [BW-1:0] sat(input logic signed [FIELD_W-1:0] v);
        logic signed [63:0] w;
        w = 64'(v);
        if (w > $signed(BMAX_U))
            return BMAX;
        else if (w < $signed(~BMAX_U))
            return BMIN;
        else
            return BW'(w);
    endfunction

    function automatic logic [FIELD_W-1:0] to_out(input logic signed [BW-1:0] x);
        logic signed [63:0] w;
        w = 64'(x);
        return w[FIELD_W-1:0];
    endfunction

    // captured beat
    logic [2:0]                mode_reg;
    logic [ITEM_W-1:0]         item_reg;
    logic [POS_W-1:0]          pos_reg;
    logic [POS_W-1:0]          rpos_reg;
    logic                      sp_reg;
    logic [POS_W-1:0]          cr_reg;
    logic signed [FIELD_W-1:0] lin_reg;
    logic signed [FIELD_W-1:0] uin_reg;

    logic [NPOS_W-1:0] np_reg;
    logic [NCON_W-1:0] nc_reg;

    // working copy of one position
    logic signed [BW-1:0] lo_reg, lo_next;
    logic signed [BW-1:0] up_reg, up_next;
    logic [PTR_W-1:0]     nptr_reg;
    logic                 nv_reg;
    logic [POS_W-1:0]     reached_reg;
    logic                 s1v_reg;
    logic [ITEM_W-1:0]    s1p_reg;
    logic [PW-1:0]        cnt_reg;

    logic                      out_valid_reg;
    logic signed [FIELD_W-1:0] lower_out_reg;
    logic signed [FIELD_W-1:0] upper_out_reg;
    logic                      feasible_reg;
    logic [1:0]                status_reg;

    logic [NPW-1:0] np_eff;
    logic [NCW-1:0] nc_eff;
    logic [PW-1:0]  pos_addr;
    logic [PW-1:0]  pos1_addr;

    logic                cons_we;
    logic [CONS_DW-1:0]  cons_rdata;
    logic [START_DW-1:0] start_rdata;
    logic                state_we;
    logic [PW-1:0]       state_waddr;
    logic [STATE_DW-1:0] state_wdata;
    logic [STATE_DW-1:0] state_rdata;
    logic [STATE_DW-1:0] wb_data;
    logic                snap_we;
    logic [STATE_DW-1:0] snap_rdata;

    logic [POS_W-1:0]     c_right;
    logic signed [BW-1:0] c_lo, c_up;
    logic signed [BW-1:0] s_lo, s_up;
    logic                 s_nv;
    logic [PTR_W-1:0]     s_nptr;
    logic [POS_W-1:0]     s_reached;
    logic signed [BW-1:0] isect_lo, isect_up;
    logic [POS_W-1:0]     target;
    logic                 k_lt_nc;
    logic                 p1_ok;
    logic                 go;
    logic                 blk;
    logic                 nv_final;
    logic                 res_ok;
    logic                 feas;

    assign np_eff = (NPW'(np_reg) < NPW'(MAX_POSITIONS)) ? NPW'(np_reg) : NPW'(MAX_POSITIONS);
    assign nc_eff = (NCW'(nc_reg) < NCW'(MAX_CONSTRAINTS)) ?
                    NCW'(nc_reg) : NCW'(MAX_CONSTRAINTS);
    assign pos_addr  = PW'(pos_reg);
    assign pos1_addr = PW'(NPW'(pos_reg) + NPW'(1));

    assign {c_right, c_lo, c_up} = cons_rdata;
    assign {s_nv, s_nptr, s_reached, s_lo, s_up} = state_rdata;

    assign target  = (mode_reg == MODE_PREPARE) ? pos_reg : rpos_reg;
    assign k_lt_nc = NCW'(nptr_reg) < nc_eff;
    assign p1_ok   = (NPW'(pos_reg) + NPW'(1)) < np_eff;
    assign go      = nv_reg && k_lt_nc && (c_right == target);
    // the next position's first constraint ends this position's run
    assign blk     = p1_ok && s1v_reg && (nptr_reg >= PTR_W'(s1p_reg));
    assign nv_final = nv_reg && ((mode_reg != MODE_PREPARE) || k_lt_nc);
    assign wb_data = {nv_final, nptr_reg, reached_reg, lo_reg, up_reg};

    // intersection source: next position's bound on merge, constraint on walk
    always_comb
    begin
        isect_lo = cmd.merge_next ? s_lo : c_lo;
        isect_up = cmd.merge_next ? s_up : c_up;
    end

    always_comb
    begin
        lo_next = lo_reg;
        up_next = up_reg;
        if (cmd.load_self)
        begin
            lo_next = s_lo;
            up_next = s_up;
        end
        else if (cmd.init_prep)
        begin
            lo_next = BMIN;
            up_next = BMAX;
        end
        else if (cmd.merge_next || (cmd.walk_step && go && !blk))
        begin
            lo_next = (isect_lo > lo_reg) ? isect_lo : lo_reg;
            up_next = (isect_up < up_reg) ? isect_up : up_reg;
        end
    end

    always_comb
    begin
        unique case (mode_reg)
            MODE_LOAD_CONS:  sts.mode_ok = NCW'(item_reg) < nc_eff;
            MODE_LOAD_START: sts.mode_ok = NPW'(pos_reg) < np_eff;
            MODE_PREPARE:    sts.mode_ok = NPW'(pos_reg) < np_eff;
            MODE_QUERY:      sts.mode_ok = (pos_reg < rpos_reg) && (NPW'(rpos_reg) < np_eff);
            default:         sts.mode_ok = 1'b0;
        endcase
    end

    assign sts.mode       = mode_reg;
    assign sts.reached_eq = reached_reg == rpos_reg;
    assign sts.walk_go    = go;
    assign sts.walk_block = blk;
    assign sts.cnt_last   = (NPW'(cnt_reg) + NPW'(1)) == np_eff;
    assign sts.np_zero    = np_eff == '0;
    assign sts.out_busy   = out_valid_reg && out_stall;

    assign res_ok = sts.mode_ok && ((mode_reg == MODE_PREPARE) || (mode_reg == MODE_QUERY));
    assign feas   = lo_reg <= up_reg;

    assign cons_we     = cmd.wr_load && (mode_reg == MODE_LOAD_CONS);
    assign state_we    = cmd.write_back || cmd.copy_snap;
    assign state_waddr = cmd.copy_snap ? cnt_reg : pos_addr;
    assign state_wdata = cmd.copy_snap ? snap_rdata : wb_data;
    assign snap_we     = cmd.write_back && (mode_reg == MODE_PREPARE);

    ibit_ram #(.WIDTH(CONS_DW), .DEPTH(MAX_CONSTRAINTS)) u_cons_ram (
        .clk   (clk),
        .we    (cons_we),
        .waddr (CW'(item_reg)),
        .wdata ({cr_reg, sat(lin_reg), sat(uin_reg)}),
        .raddr (CW'(nptr_reg)),
        .rdata (cons_rdata)
    );

    ibit_ram #(.WIDTH(START_DW), .DEPTH(MAX_POSITIONS)) u_start_ram (
        .clk   (clk),
        .we    (cmd.wr_load && (mode_reg == MODE_LOAD_START)),
        .waddr (pos_addr),
        .wdata ({sp_reg, item_reg}),
        .raddr (cmd.rd_start1 ? pos1_addr : pos_addr),
        .rdata (start_rdata)
    );

    ibit_ram #(.WIDTH(STATE_DW), .DEPTH(MAX_POSITIONS)) u_state_ram (
        .clk   (clk),
        .we    (state_we),
        .waddr (state_waddr),
        .wdata (state_wdata),
        .raddr (cmd.rd_next ? pos1_addr : pos_addr),
        .rdata (state_rdata)
    );

    ibit_ram #(.WIDTH(STATE_DW), .DEPTH(MAX_POSITIONS)) u_snap_ram (
        .clk   (clk),
        .we    (snap_we),
        .waddr (pos_addr),
        .wdata (wb_data),
        .raddr (cnt_reg),
        .rdata (snap_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            np_reg        <= NPOS_W'(1);
            nc_reg        <= NCON_W'(1);
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_NUM_POSITIONS:   np_reg <= cfg_data[NPOS_W-1:0];
                    CFG_NUM_CONSTRAINTS: nc_reg <= cfg_data;
                    default:             nc_reg <= nc_reg;
                endcase
            end
            if (cmd.clr_cnt)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.copy_snap)
            begin
                cnt_reg <= cnt_reg + PW'(1);
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg <= mode;
            item_reg <= item_index;
            pos_reg  <= position;
            rpos_reg <= right_position;
            sp_reg   <= start_present;
            cr_reg   <= constraint_right;
            lin_reg  <= lower_in;
            uin_reg  <= upper_in;
        end

        lo_reg <= lo_next;
        up_reg <= up_next;

        if (cmd.load_self)
        begin
            nptr_reg    <= s_nptr;
            nv_reg      <= s_nv;
            reached_reg <= s_reached;
        end
        else if (cmd.init_prep)
        begin
            nptr_reg    <= PTR_W'(start_rdata[ITEM_W-1:0]);
            nv_reg      <= start_rdata[ITEM_W];
            reached_reg <= pos_reg;
        end
        else if (cmd.merge_next)
        begin
            reached_reg <= rpos_reg;
        end
        else if (cmd.walk_step && go)
        begin
            if (blk)
            begin
                nv_reg <= 1'b0;
            end
            else
            begin
                nptr_reg <= nptr_reg + PTR_W'(1);
            end
        end

        if (cmd.latch_start1)
        begin
            s1v_reg <= start_rdata[ITEM_W];
            s1p_reg <= start_rdata[ITEM_W-1:0];
        end

        if (cmd.finish)
        begin
            lower_out_reg <= res_ok ? to_out(lo_reg) : '0;
            upper_out_reg <= res_ok ? to_out(up_reg) : '0;
            feasible_reg  <= res_ok && feas;
            if (mode_reg == MODE_RESTORE)
                status_reg <= ST_OK;
            else if (!sts.mode_ok)
                status_reg <= ST_BAD_INDEX;
            else if ((mode_reg == MODE_PREPARE) && !feas)
                status_reg <= ST_INFEASIBLE;
            else
                status_reg <= ST_OK;
        end
    end

    assign out_valid = out_valid_reg;
    assign lower_out = lower_out_reg;
    assign upper_out = upper_out_reg;
    assign feasible  = feasible_reg;
    assign status    = status_reg;

endmodule

>>> src/interval_bound_intersection_table.sv
// one beat at a time; the next beat is taken after the result is loaded
// load: table write, finish; prepare: start reads, constraint walk, write-back;
// query: read, done if cached, else merge with next position, walk and write-back;
// walk: a read and a check per constraint; restore copies back each position's snapshot
// reset (rst_n low, async) idles control, sizes reset to one; tables unset until written
module interval_bound_intersection_table #(
    parameter int MAX_POSITIONS   = 1024,
    parameter int MAX_CONSTRAINTS = 4096,
    parameter int BOUND_WIDTH     = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic [ibit_pkg::CFG_W-1:0]          cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [2:0]                          mode,
    input  logic [ibit_pkg::ITEM_W-1:0]         item_index,
    input  logic [ibit_pkg::POS_W-1:0]          position,
    input  logic [ibit_pkg::POS_W-1:0]          right_position,
    input  logic                                start_present,
    input  logic [ibit_pkg::POS_W-1:0]          constraint_right,
    input  logic signed [ibit_pkg::FIELD_W-1:0] lower_in,
    input  logic signed [ibit_pkg::FIELD_W-1:0] upper_in,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [ibit_pkg::FIELD_W-1:0] lower_out,
    output logic signed [ibit_pkg::FIELD_W-1:0] upper_out,
    output logic                                feasible,
    output logic [1:0]                          status
);
    import ibit_pkg::*;

    ibit_cmd_t cmd;
    ibit_sts_t sts;

    ibit_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    ibit_dp #(
        .MAX_POSITIONS   (MAX_POSITIONS),
        .MAX_CONSTRAINTS (MAX_CONSTRAINTS),
        .BOUND_WIDTH     (BOUND_WIDTH)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .mode             (mode),
        .item_index       (item_index),
        .position         (position),
        .right_position   (right_position),
        .start_present    (start_present),
        .constraint_right (constraint_right),
        .lower_in         (lower_in),
        .upper_in         (upper_in),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .lower_out        (lower_out),
        .upper_out        (upper_out),
        .feasible         (feasible),
        .status           (status),
        .cmd              (cmd),
        .sts              (sts)
    );

endmodule

>>> src/ibit_checker.sv
`include "assert_macros.svh"

module ibit_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_stall,
    input logic                                out_valid,
    input logic                                out_stall,
    input logic signed [ibit_pkg::FIELD_W-1:0] lower_out,
    input logic signed [ibit_pkg::FIELD_W-1:0] upper_out,
    input logic                                feasible,
    input logic [1:0]                          status
);
    import ibit_pkg::*;

    // a held result beat stays put
    `IBIT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(lower_out) && $stable(upper_out) && $stable(status))

    // one beat in flight: busy right after accept
    `IBIT_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)

    `IBIT_ASSERT_NOW(a_status_code, clk, rst_n, out_valid, (status == ST_OK) || (status == ST_BAD_INDEX) || (status == ST_INFEASIBLE))

    // bad index results carry no bound
    `IBIT_ASSERT_NOW(a_bad_zero, clk, rst_n, out_valid && (status == ST_BAD_INDEX), (lower_out == '0) && (upper_out == '0) && !feasible)

    `IBIT_ASSERT_NOW(a_feasible_ok, clk, rst_n, out_valid && feasible, status == ST_OK)

endmodule

bind interval_bound_intersection_table ibit_checker u_ibit_checker (.*);

>>> dv/testbench.sv
module testbench;
    import ibit_pkg::*;

    localparam int BOUND_MIN = 32'sh80000000;
    localparam int BOUND_MAX = 32'sh7fffffff;

    typedef struct {
        logic [2:0]         mode;
        logic [ITEM_W-1:0]  item;
        logic [POS_W-1:0]   pos;
        logic [POS_W-1:0]   rpos;
        logic               present;
        logic [POS_W-1:0]   cright;
        logic signed [31:0] lo;
        logic signed [31:0] up;
    } beat_t;

    typedef struct {
        logic signed [31:0] lo;
        logic signed [31:0] up;
        logic               feas;
        logic [1:0]         status;
    } bound_res_t;

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_we = 0;
    logic cfg_index = 0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic in_valid = 0;
    logic in_stall;
    logic out_valid;
    logic out_stall = 0;
    logic signed [31:0] lower_out, upper_out;
    logic feasible;
    logic [1:0] status;
    beat_t drv = '{default: '0};

    interval_bound_intersection_table DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .mode(drv.mode), .item_index(drv.item), .position(drv.pos),
        .right_position(drv.rpos), .start_present(drv.present),
        .constraint_right(drv.cright), .lower_in(drv.lo), .upper_in(drv.up),
        .out_valid(out_valid), .out_stall(out_stall),
        .lower_out(lower_out), .upper_out(upper_out),
        .feasible(feasible), .status(status)
    );

    always #5 clk = ~clk;

    beat_t pending_beats[$];
    bound_res_t bounds_due[$];
    int errors = 0;
    bit quiet = 0;
    bit hold_req = 0;
    bit beat_taken = 0;
    int send_gap = 0;
    int recv_gap = 0;
    int hold_cnt = 0;

    // shadow of the table
    int unsigned np_eff = 1, nc_eff = 1;
    logic [POS_W-1:0] c_right[4096];
    int c_lo[4096], c_up[4096];
    int unsigned s_ptr[1024], n_ptr[1024], reach[1024], sn_ptr[1024], sn_reach[1024];
    bit s_ok[1024], n_ok[1024], sn_ok[1024];
    int r_lo[1024], r_up[1024], sn_lo[1024], sn_up[1024];

    function automatic void narrow(int unsigned p, int lo, int up);
        if (lo > r_lo[p]) r_lo[p] = lo;
        if (up < r_up[p]) r_up[p] = up;
    endfunction

    // absorb constraints of p that end at target, stop at the next position's first one
    function automatic void fold_walk(int unsigned p, int unsigned target);
        int unsigned k;
        bit go;
        go = 1;
        while (go && n_ok[p] && n_ptr[p] < nc_eff && c_right[n_ptr[p]] == target) begin
            k = n_ptr[p];
            if (p + 1 < np_eff && s_ok[p + 1] && k >= s_ptr[p + 1]) begin
                n_ok[p] = 0;
                go = 0;
            end
            else begin
                narrow(p, c_lo[k], c_up[k]);
                n_ptr[p] = k + 1;
            end
        end
    endfunction

    function automatic bound_res_t predict_bounds(beat_t b);
        bound_res_t r;
        int unsigned p, rp;
        r = '{lo: 0, up: 0, feas: 0, status: ST_OK};
        p = 32'(b.pos);
        rp = 32'(b.rpos);
        case (b.mode)
            MODE_LOAD_CONS: begin
                if (b.item < nc_eff) begin
                    c_right[b.item] = b.cright;
                    c_lo[b.item] = b.lo;
                    c_up[b.item] = b.up;
                end
                else r.status = ST_BAD_INDEX;
            end
            MODE_LOAD_START: begin
                if (p < np_eff) begin
                    s_ptr[p] = 32'(b.item);
                    s_ok[p] = b.present;
                end
                else r.status = ST_BAD_INDEX;
            end
            MODE_PREPARE: begin
                if (p < np_eff) begin
                    r_lo[p] = BOUND_MIN;
                    r_up[p] = BOUND_MAX;
                    reach[p] = p;
                    n_ptr[p] = s_ptr[p];
                    n_ok[p] = s_ok[p];
                    fold_walk(p, p);
                    if (n_ok[p] && n_ptr[p] >= nc_eff) n_ok[p] = 0;
                    sn_lo[p] = r_lo[p];
                    sn_up[p] = r_up[p];
                    sn_ptr[p] = n_ptr[p];
                    sn_ok[p] = n_ok[p];
                    sn_reach[p] = reach[p];
                    r.lo = r_lo[p];
                    r.up = r_up[p];
                    r.feas = r_lo[p] <= r_up[p];
                    r.status = r.feas ? ST_OK : ST_INFEASIBLE;
                end
                else r.status = ST_BAD_INDEX;
            end
            MODE_QUERY: begin
                if (p < rp && rp < np_eff) begin
                    if (reach[p] != rp) begin
                        narrow(p, r_lo[p + 1], r_up[p + 1]);
                        fold_walk(p, rp);
                        reach[p] = rp;
                    end
                    r.lo = r_lo[p];
                    r.up = r_up[p];
                    r.feas = r_lo[p] <= r_up[p];
                end
                else r.status = ST_BAD_INDEX;
            end
            MODE_RESTORE: begin
                for (int unsigned i = 0; i < np_eff; i++) begin
                    r_lo[i] = sn_lo[i];
                    r_up[i] = sn_up[i];
                    n_ptr[i] = sn_ptr[i];
                    n_ok[i] = sn_ok[i];
                    reach[i] = sn_reach[i];
                end
            end
            default: r.status = ST_BAD_INDEX;
        endcase
        return r;
    endfunction

    // sender
    always @(negedge clk) begin
        if (rst_n && (!in_valid || beat_taken)) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                in_valid <= 0;
            end
            else if (!quiet && $urandom_range(0, 9) == 0) begin
                send_gap <= $urandom_range(0, 7);
                in_valid <= 0;
            end
            else if (pending_beats.size() > 0) begin
                drv <= pending_beats.pop_front();
                in_valid <= 1;
            end
            else in_valid <= 0;
        end
    end

    // receiver
    always @(negedge clk) begin
        if (rst_n) begin
            if (hold_cnt > 0) begin
                hold_cnt <= hold_cnt - 1;
                out_stall <= 1;
            end
            else if (hold_req) begin
                hold_req <= 0;
                hold_cnt <= 80;
                out_stall <= 1;
            end
            else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                out_stall <= 1;
            end
            else if (!quiet && $urandom_range(0, 7) == 0) begin
                recv_gap <= $urandom_range(0, 7);
                out_stall <= 1;
            end
            else out_stall <= 0;
        end
    end

    always @(posedge clk) begin
        bound_res_t e;
        beat_taken <= in_valid && !in_stall;
        if (in_valid && !in_stall) bounds_due.push_back(predict_bounds(drv));
        if (out_valid && !out_stall) begin
            if (bounds_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat lo=%h up=%h", $time, lower_out, upper_out);
            end
            else begin
                e = bounds_due.pop_front();
                if (lower_out !== e.lo || upper_out !== e.up || feasible !== e.feas
                    || status !== e.status) begin
                    errors++;
                    $display("%0t: mismatch exp lo=%h up=%h feas=%b st=%0d act lo=%h up=%h feas=%b st=%0d",
                             $time, e.lo, e.up, e.feas, e.status,
                             lower_out, upper_out, feasible, status);
                end
            end
        end
    end

    function automatic beat_t rand_beat();
        beat_t b;
        b.mode = 3'($urandom_range(0, 7));
        b.item = ITEM_W'($urandom);
        b.pos = POS_W'($urandom);
        b.rpos = POS_W'($urandom);
        b.present = 1'($urandom);
        b.cright = POS_W'($urandom);
        b.lo = $urandom;
        b.up = $urandom;
        return b;
    endfunction

    function automatic void rand_bounds(ref beat_t b);
        int base;
        case ($urandom_range(0, 7))
            0: b.lo = BOUND_MIN;
            1: b.up = BOUND_MAX;
            2: ;
            3: begin
                b.lo = BOUND_MIN;
                b.up = BOUND_MAX;
            end
            default: begin
                base = (int'($urandom_range(0, 2000)) - 1000) <<< 12;
                b.lo = base;
                b.up = base + (int'($urandom_range(0, 3000)) - 200) * 64;
            end
        endcase
    endfunction

    task automatic wait_drained();
        do begin
            @(posedge clk);
            #1;
        end while (pending_beats.size() != 0 || in_valid || bounds_due.size() != 0);
        repeat (5) @(posedge clk);
        #1;
    endtask

    task automatic write_reg(logic idx, int unsigned val);
        @(negedge clk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= CFG_W'(val);
        @(negedge clk);
        cfg_we <= 0;
        if (idx == CFG_NUM_POSITIONS) np_eff = (val & 'h7ff) < 1024 ? (val & 'h7ff) : 1024;
        else nc_eff = (val & 'h1fff) < 4096 ? (val & 'h1fff) : 4096;
    endtask

    // well-formed table: constraints sorted by left position, each start after its constraints, then prepares
    task automatic setup_phase(int unsigned npv, int unsigned ncv);
        beat_t b;
        int unsigned k, cnt, rr;
        wait_drained();
        write_reg(CFG_NUM_POSITIONS, npv);
        write_reg(CFG_NUM_CONSTRAINTS, ncv);
        k = 0;
        for (int unsigned p = 0; p < np_eff; p++) begin
            b = rand_beat();
            b.mode = MODE_LOAD_START;
            b.pos = POS_W'(p);
            b.present = (k < nc_eff) && ($urandom_range(0, 3) != 0);
            if (b.present) begin
                b.item = ITEM_W'(k);
                cnt = $urandom_range(1, 3);
                if (cnt > nc_eff - k) cnt = nc_eff - k;
                rr = p;
                for (int unsigned j = 0; j < cnt; j++) begin
                    beat_t c;
                    c = rand_beat();
                    c.mode = MODE_LOAD_CONS;
                    c.item = ITEM_W'(k);
                    c.cright = POS_W'(rr > 1023 ? 1023 : rr);
                    rand_bounds(c);
                    pending_beats.push_back(c);
                    rr += $urandom_range(0, 2);
                    k++;
                end
            end
            pending_beats.push_back(b);
        end
        for (int unsigned j = k; j < nc_eff; j++) begin
            b = rand_beat();
            b.mode = MODE_LOAD_CONS;
            b.item = ITEM_W'(j);
            rand_bounds(b);
            pending_beats.push_back(b);
        end
        for (int p = int'(np_eff) - 1; p >= 0; p--) begin
            b = rand_beat();
            b.mode = MODE_PREPARE;
            b.pos = POS_W'(p);
            pending_beats.push_back(b);
        end
    endtask

    task automatic random_part(int n, int restore_pct);
        beat_t b;
        int sel;
        for (int i = 0; i < n; i++) begin
            b = rand_beat();
            sel = $urandom_range(0, 99);
            if (sel < 60 && np_eff >= 2) begin
                b.mode = MODE_QUERY;
                b.pos = POS_W'($urandom_range(0, np_eff - 2));
                b.rpos = POS_W'($urandom_range(32'(b.pos) + 1, np_eff - 1));
            end
            else if (sel < 72 && np_eff >= 1) begin
                b.mode = MODE_PREPARE;
                b.pos = POS_W'($urandom_range(0, np_eff - 1));
            end
            else if (sel < 72 + restore_pct) b.mode = MODE_RESTORE;
            else if (sel < 80 && np_eff >= 1) begin
                b.mode = MODE_LOAD_START;
                b.pos = POS_W'($urandom_range(0, np_eff - 1));
            end
            else if (sel < 86 && nc_eff >= 1) begin
                b.mode = MODE_LOAD_CONS;
                b.item = ITEM_W'($urandom_range(0, nc_eff - 1));
                rand_bounds(b);
            end
            else if (b.mode == MODE_RESTORE && np_eff > 256) b.mode = MODE_QUERY;
            pending_beats.push_back(b);
        end
    endtask

    task automatic push_mode(logic [2:0] m, int unsigned item, int unsigned p, int unsigned rp);
        beat_t b;
        b = rand_beat();
        b.mode = m;
        b.item = ITEM_W'(item);
        b.pos = POS_W'(p);
        b.rpos = POS_W'(rp);
        pending_beats.push_back(b);
    endtask

    initial begin
        beat_t b;
        repeat (2) @(posedge clk);
        #1;
        rst_n = 1;

        setup_phase(8, 16);
        push_mode(3'd5, 0, 0, 1);
        push_mode(3'd6, 0, 0, 1);
        push_mode(3'd7, 0, 0, 1);
        push_mode(MODE_LOAD_CONS, 16, 0, 0);
        push_mode(MODE_LOAD_CONS, 4095, 0, 0);
        push_mode(MODE_LOAD_START, 0, 8, 0);
        push_mode(MODE_LOAD_START, 0, 1023, 0);
        push_mode(MODE_PREPARE, 0, 8, 0);
        push_mode(MODE_QUERY, 0, 3, 3);
        push_mode(MODE_QUERY, 0, 5, 2);
        push_mode(MODE_QUERY, 0, 0, 8);
        push_mode(MODE_QUERY, 0, 1023, 1023);
        for (int r = 1; r < 8; r++) push_mode(MODE_QUERY, 0, r - 1, r);
        push_mode(MODE_QUERY, 0, 0, 7);
        push_mode(MODE_RESTORE, 0, 0, 0);
        push_mode(MODE_QUERY, 0, 0, 7);
        random_part(150, 4);

        setup_phase(1, 1);
        random_part(60, 5);
        setup_phase(0, 0);
        random_part(40, 5);

        // oversized config clamps to the table sizes
        wait_drained();
        write_reg(CFG_NUM_POSITIONS, 2047);
        write_reg(CFG_NUM_CONSTRAINTS, 8191);
        b = rand_beat();
        b.mode = MODE_LOAD_START;
        b.pos = POS_W'(1023);
        b.present = 0;
        pending_beats.push_back(b);
        push_mode(MODE_LOAD_CONS, 4095, 0, 0);
        push_mode(MODE_PREPARE, 0, 1023, 0);
        push_mode(MODE_QUERY, 0, 1023, 1023);

        // sender keeps offering while the receiver holds off
        setup_phase(40, 80);
        wait_drained();
        hold_req = 1;
        random_part(300, 4);

        setup_phase(100, 150);
        random_part(200, 3);

        setup_phase(16, 24);
        wait_drained();
        quiet = 1;
        random_part(350, 4);

        wait_drained();
        repeat (20) @(posedge clk);
        if (errors == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end

    initial begin
        #20000000;
        $display("Regression FAIL");
        $finish;
    end
endmodule

>>> files.f
+incdir+src
src/ibit_pkg.sv
src/ibit_ram.sv
src/ibit_ctrl.sv
src/ibit_dp.sv
src/interval_bound_intersection_table.sv
src/ibit_checker.sv
dv/testbench.sv
